[rtl/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, constants and helper functions of the layered ring tree
// path search block.
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int MAX_LAYERS      = 6;
    localparam int NODE_W          = 6;
    localparam int NB_NODE_W       = NODE_W + 1;
    localparam int NODE_SLOTS      = 1 << NODE_W;
    localparam int LAYER_W         = 3;
    localparam int CFG_W           = 3;
    localparam int ALT_WIDTH       = 16;
    localparam int DIFF_W          = ALT_WIDTH + 1;
    localparam int COST_W          = 23;
    localparam int PRIO_W          = 24;
    localparam int PATH_W          = 22;
    localparam int QENT_W          = PRIO_W + NODE_W;
    localparam int NBI_W           = 3;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int DIN_W           = 40;
    localparam int DOUT_W          = 32;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};
    localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

    typedef logic [NODE_W-1:0]           node_t;
    typedef logic signed [ALT_WIDTH-1:0] alt_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALT_G,
        ST_TOTAL,
        ST_LOOP,
        ST_SCAN,
        ST_POP_RD,
        ST_POP_WR,
        ST_POP_CHK,
        ST_NB_RD,
        ST_NB_D,
        ST_NB_EV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ASEL_START,
        ASEL_GOAL,
        ASEL_U,
        ASEL_V
    } alt_sel_t;

    typedef enum logic {
        BSEL_U,
        BSEL_V
    } bc_sel_t;

    typedef enum logic [2:0] {
        RK_WRITE,
        RK_REJECT,
        RK_FOUND,
        RK_NONE,
        RK_OVF
    } res_kind_t;

    typedef struct packed {
        logic      latch_item;
        logic      alt_wr;
        alt_sel_t  alt_sel;
        bc_sel_t   bc_sel;
        logic      init_search;
        logic      cap_alt_start;
        logic      cap_total;
        logic      scan_start;
        logic      scan_step;
        logic      pop_rd_last;
        logic      pop_wr;
        logic      cap_u;
        logic      nb_next;
        logic      cap_d;
        logic      relax;
        logic      pend_set;
        res_kind_t pend_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    item_ok;
        logic    scan_done;
        logic    queue_empty;
        logic    u_is_goal;
        logic    nb_valid;
        logic    nb_last;
        logic    relax_take;
        logic    queue_full;
    } sts_t;

    // floor(log2(n)), zero for n of zero or one
    function automatic logic [LAYER_W-1:0] layer_of(input node_t n);
        logic [LAYER_W-1:0] k;
        k = '0;
        for (int i = 0; i < NODE_W; i++) begin
            if (n[i]) begin
                k = LAYER_W'(i);
            end
        end
        return k;
    endfunction

    // neighbor j of u in visiting order; parent of the root comes out as 0
    function automatic logic [NB_NODE_W-1:0] nb_node(input node_t u,
                                                      input logic [NBI_W-1:0] j,
                                                      input logic leaf);
        logic [NB_NODE_W-1:0] u7;
        logic [NB_NODE_W-1:0] base;
        logic [NB_NODE_W-1:0] top;
        logic [NB_NODE_W-1:0] left;
        logic [NB_NODE_W-1:0] right;
        logic [NB_NODE_W-1:0] par;
        logic [NB_NODE_W-1:0] res;
        u7    = {1'b0, u};
        base  = NB_NODE_W'(1) << layer_of(u);
        top   = (base << 1) - NB_NODE_W'(1);
        left  = (u7 == base) ? top : u7 - NB_NODE_W'(1);
        right = (u7 == top) ? base : u7 + NB_NODE_W'(1);
        par   = u7 >> 1;
        res   = '0;
        if (leaf) begin
            case (j)
                3'd0:    res = left;
                3'd1:    res = right;
                3'd2:    res = par;
                default: res = '0;
            endcase
        end else begin
            case (j)
                3'd0:    res = u7 << 1;
                3'd1:    res = (u7 << 1) | NB_NODE_W'(1);
                3'd2:    res = par;
                3'd3:    res = left;
                3'd4:    res = right;
                default: res = '0;
            endcase
        end
        return res;
    endfunction

endpackage

[rtl/lrt_ctrl.sv]
// ----------------------------------------------------------------------------
// lrt_ctrl
// Sequencer of the path search: item intake, search loop (scan, pop,
// neighbor relax) and the result register handshake.
// ----------------------------------------------------------------------------
module lrt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  lrt_pkg::sts_t sts,
    output lrt_pkg::cmd_t cmd
);
    import lrt_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.alt_sel    = ASEL_V;
        cmd.bc_sel     = BSEL_V;
        cmd.pend_kind  = RK_NONE;
        m_valid_next   = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.latch_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.alt_sel = ASEL_START;
                if (sts.op == OP_WRITE) begin
                    cmd.alt_wr    = sts.item_ok;
                    cmd.pend_set  = 1'b1;
                    cmd.pend_kind = RK_WRITE;
                    state_next    = ST_FINISH;
                end else if (!sts.item_ok) begin
                    cmd.pend_set  = 1'b1;
                    cmd.pend_kind = RK_REJECT;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.init_search = 1'b1;
                    state_next      = ST_ALT_G;
                end
            end
            ST_ALT_G: begin
                cmd.cap_alt_start = 1'b1;
                cmd.alt_sel       = ASEL_GOAL;
                state_next        = ST_TOTAL;
            end
            ST_TOTAL: begin
                cmd.alt_sel   = ASEL_GOAL;
                cmd.cap_total = 1'b1;
                state_next    = ST_LOOP;
            end
            ST_LOOP: begin
                if (sts.queue_empty) begin
                    cmd.pend_set  = 1'b1;
                    cmd.pend_kind = RK_NONE;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                cmd.pop_rd_last = 1'b1;
                state_next      = ST_POP_WR;
            end
            ST_POP_WR: begin
                cmd.pop_wr  = 1'b1;
                cmd.alt_sel = ASEL_U;
                cmd.bc_sel  = BSEL_U;
                state_next  = ST_POP_CHK;
            end
            ST_POP_CHK: begin
                cmd.alt_sel = ASEL_U;
                cmd.bc_sel  = BSEL_U;
                cmd.cap_u   = 1'b1;
                if (sts.u_is_goal) begin
                    cmd.pend_set  = 1'b1;
                    cmd.pend_kind = RK_FOUND;
                    state_next    = ST_FINISH;
                end else begin
                    state_next = ST_NB_RD;
                end
            end
            ST_NB_RD: begin
                if (sts.nb_valid) begin
                    state_next = ST_NB_D;
                end else if (sts.nb_last) begin
                    state_next = ST_LOOP;
                end else begin
                    cmd.nb_next = 1'b1;
                end
            end
            ST_NB_D: begin
                cmd.cap_d  = 1'b1;
                state_next = ST_NB_EV;
            end
            ST_NB_EV: begin
                if (sts.relax_take && sts.queue_full) begin
                    cmd.relax     = 1'b1;
                    cmd.pend_set  = 1'b1;
                    cmd.pend_kind = RK_OVF;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.relax = sts.relax_take;
                    if (sts.nb_last) begin
                        state_next = ST_LOOP;
                    end else begin
                        cmd.nb_next = 1'b1;
                        state_next  = ST_NB_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ready_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready outside idle");

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded");

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_valid_reg || m_tready)) |=>
        (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not presented");

endmodule

[rtl/lrt_dpath.sv]
// ----------------------------------------------------------------------------
// lrt_dpath
// Datapath: altitude and cost memories, seen flags, open queue memory with
// its linear min scan, neighbor generation, relax arithmetic, result regs.
// ----------------------------------------------------------------------------
module lrt_dpath #(
    parameter int QUEUE_DEPTH = lrt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrt_pkg::cmd_t                cmd,
    output lrt_pkg::sts_t                sts,
    input  logic [lrt_pkg::DIN_W-1:0]    s_tdata,
    input  logic                         s_tuser,
    input  logic                         cfg_wr,
    input  logic [lrt_pkg::CFG_W-1:0]    cfg_data,
    output logic [lrt_pkg::DOUT_W-1:0]   res_tdata
);
    import lrt_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] QFULL = CW'(QUEUE_DEPTH);

    // configuration
    logic [CFG_W-1:0]     layer_count_reg;
    logic [LAYER_W-1:0]   lay;
    logic [NB_NODE_W-1:0] limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= CFG_W'(MAX_LAYERS);
        end else if (cfg_wr) begin
            layer_count_reg <= cfg_data;
        end
    end

    assign lay   = (layer_count_reg > CFG_W'(MAX_LAYERS)) ? LAYER_W'(MAX_LAYERS)
                                                          : layer_count_reg;
    assign limit = NB_NODE_W'(1) << lay;

    // item registers
    opcode_t op_reg;
    node_t   node_reg, start_reg, goal_reg;
    alt_t    altw_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            op_reg    <= opcode_t'(s_tuser);
            node_reg  <= s_tdata[5:0];
            altw_reg  <= s_tdata[21:6];
            start_reg <= s_tdata[27:22];
            goal_reg  <= s_tdata[33:28];
        end
    end

    function automatic logic node_ok(input node_t n, input logic [NB_NODE_W-1:0] lim);
        return (n != '0) && ({1'b0, n} < lim);
    endfunction

    // altitude memory, entries never written read as zero
    alt_t               alt_mem [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] alt_vld_reg;
    alt_t               alt_q_reg;
    logic               alt_qv_reg;
    alt_t               alt_rd;
    node_t              alt_addr;
    node_t              best_node_reg;
    node_t              u;
    logic [NB_NODE_W-1:0] v;
    node_t              v6;

    assign u  = best_node_reg;
    assign v6 = v[NODE_W-1:0];

    always_comb begin
        case (cmd.alt_sel)
            ASEL_START: alt_addr = start_reg;
            ASEL_GOAL:  alt_addr = goal_reg;
            ASEL_U:     alt_addr = u;
            default:    alt_addr = v6;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.alt_wr) begin
            alt_mem[node_reg] <= altw_reg;
        end
        alt_q_reg  <= alt_mem[alt_addr];
        alt_qv_reg <= alt_vld_reg[alt_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alt_vld_reg <= '0;
        end else if (cmd.alt_wr) begin
            alt_vld_reg[node_reg] <= 1'b1;
        end
    end

    assign alt_rd = alt_qv_reg ? alt_q_reg : '0;

    // best cost memory and seen flags
    logic [COST_W-1:0] bc_mem [NODE_SLOTS];
    logic [COST_W-1:0] bc_q_reg;
    logic [NODE_SLOTS-1:0] seen_reg;
    logic [COST_W-1:0] c_val;

    always_ff @(posedge aclk) begin
        if (cmd.init_search) begin
            bc_mem[start_reg] <= '0;
        end else if (cmd.relax) begin
            bc_mem[v6] <= c_val;
        end
        bc_q_reg <= bc_mem[(cmd.bc_sel == BSEL_U) ? u : v6];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (cmd.init_search) begin
            seen_reg <= NODE_SLOTS'(1) << start_reg;
        end else if (cmd.relax) begin
            seen_reg[v6] <= 1'b1;
        end
    end

    // search scalars
    alt_t              alt_start_reg, u_alt_reg;
    logic [DIFF_W-1:0] total_reg, d_reg;
    logic [COST_W-1:0] u_cost_reg;
    logic [NBI_W-1:0]  j_reg;

    function automatic logic [DIFF_W-1:0] alt_absdiff(input alt_t a, input alt_t b);
        logic signed [DIFF_W-1:0] df;
        df = DIFF_W'(a) - DIFF_W'(b);
        return df[DIFF_W-1] ? DIFF_W'(-df) : DIFF_W'(df);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.cap_alt_start) begin
            alt_start_reg <= alt_rd;
        end
        if (cmd.cap_total) begin
            total_reg <= alt_absdiff(alt_start_reg, alt_rd);
        end
        if (cmd.cap_u) begin
            u_cost_reg <= bc_q_reg;
            u_alt_reg  <= alt_rd;
        end
        if (cmd.cap_d) begin
            d_reg <= alt_absdiff(u_alt_reg, alt_rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg <= '0;
        end else if (cmd.cap_u) begin
            j_reg <= '0;
        end else if (cmd.nb_next) begin
            j_reg <= j_reg + NBI_W'(1);
        end
    end

    // neighbor generation
    logic leaf;
    assign leaf = ({1'b0, u} >= (limit >> 1));
    assign v    = nb_node(u, j_reg, leaf);

    // relax arithmetic
    logic [COST_W:0]    c_sum;
    logic [DIFF_W-1:0]  td;
    logic [LAYER_W-1:0] lv, lg, ld;
    logic [PRIO_W+1:0]  p_sum;
    logic [PRIO_W-1:0]  p_val;

    always_comb begin
        c_sum = {1'b0, u_cost_reg} + (COST_W+1)'(d_reg);
        c_val = (c_sum > {1'b0, COST_MAX}) ? COST_MAX : c_sum[COST_W-1:0];
        td    = (total_reg >= d_reg) ? total_reg - d_reg : d_reg - total_reg;
        lv    = layer_of(v6);
        lg    = layer_of(goal_reg);
        ld    = (lv >= lg) ? lv - lg : lg - lv;
        p_sum = (PRIO_W+2)'(c_val) + (PRIO_W+2)'(td) + (PRIO_W+2)'(ld);
        p_val = (p_sum > (PRIO_W+2)'(PRIO_MAX)) ? PRIO_MAX : p_sum[PRIO_W-1:0];
    end

    // open queue: {prio, node}
    logic [QENT_W-1:0] q_mem [QUEUE_DEPTH];
    logic [QENT_W-1:0] q_q_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     scan_addr_reg, rd_idx_reg;
    logic              rd_vld_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [QW-1:0]     best_idx_reg;
    logic [CW-1:0]     last_idx;
    logic [QW-1:0]     q_raddr;
    logic              scan_issue;
    logic              push;
    logic              better;
    logic [PRIO_W-1:0] e_prio;
    node_t             e_node;

    assign last_idx   = count_reg - CW'(1);
    assign scan_issue = cmd.scan_step && (scan_addr_reg < count_reg);
    assign q_raddr    = cmd.pop_rd_last ? last_idx[QW-1:0] : scan_addr_reg[QW-1:0];
    assign push       = cmd.relax && (count_reg < QFULL);
    assign e_prio     = q_q_reg[QENT_W-1:NODE_W];
    assign e_node     = q_q_reg[NODE_W-1:0];
    assign better     = (rd_idx_reg == '0) || (e_prio < best_prio_reg) ||
                        ((e_prio == best_prio_reg) && (e_node < best_node_reg));

    always_ff @(posedge aclk) begin
        if (cmd.init_search) begin
            q_mem[0] <= {{PRIO_W{1'b0}}, start_reg};
        end else if (cmd.pop_wr) begin
            q_mem[best_idx_reg] <= q_q_reg;
        end else if (push) begin
            q_mem[count_reg[QW-1:0]] <= {p_val, v6};
        end
        q_q_reg <= q_mem[q_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            if (cmd.init_search) begin
                count_reg <= CW'(1);
            end else if (cmd.pop_wr) begin
                count_reg <= last_idx;
            end else if (push) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.relax) begin
                count_reg <= '0;
            end
            if (cmd.scan_start) begin
                scan_addr_reg <= '0;
                rd_vld_reg    <= 1'b0;
            end else if (cmd.scan_step) begin
                rd_vld_reg <= scan_issue;
                rd_idx_reg <= scan_addr_reg;
                if (scan_issue) begin
                    scan_addr_reg <= scan_addr_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && rd_vld_reg && better) begin
            best_prio_reg <= e_prio;
            best_node_reg <= e_node;
            best_idx_reg  <= rd_idx_reg[QW-1:0];
        end
    end

    // status
    always_comb begin
        sts.op          = op_reg;
        sts.item_ok     = (op_reg == OP_WRITE) ? node_ok(node_reg, limit)
                          : (node_ok(start_reg, limit) && node_ok(goal_reg, limit));
        sts.scan_done   = rd_vld_reg && (rd_idx_reg == last_idx);
        sts.queue_empty = (count_reg == '0);
        sts.u_is_goal   = (u == goal_reg);
        sts.nb_valid    = (v != '0) && (v < limit);
        sts.nb_last     = leaf ? (j_reg == NBI_W'(2)) : (j_reg == NBI_W'(4));
        sts.relax_take  = !(seen_reg[v6] && (c_val >= bc_q_reg));
        sts.queue_full  = (count_reg >= QFULL);
    end

    // pending result and output register
    logic              pend_acc_reg, pend_found_reg, pend_ovf_reg;
    logic [PATH_W-1:0] pend_cost_reg;
    logic              res_acc_reg, res_found_reg, res_ovf_reg;
    logic [PATH_W-1:0] res_cost_reg;

    always_ff @(posedge aclk) begin
        if (cmd.pend_set) begin
            pend_acc_reg   <= 1'b0;
            pend_found_reg <= 1'b0;
            pend_ovf_reg   <= 1'b0;
            pend_cost_reg  <= '0;
            case (cmd.pend_kind)
                RK_WRITE: pend_acc_reg <= sts.item_ok;
                RK_FOUND: begin
                    pend_acc_reg   <= 1'b1;
                    pend_found_reg <= 1'b1;
                    pend_cost_reg  <= (bc_q_reg > {1'b0, PATH_MAX}) ? PATH_MAX
                                      : bc_q_reg[PATH_W-1:0];
                end
                RK_NONE:  pend_acc_reg <= 1'b1;
                RK_OVF: begin
                    pend_acc_reg <= 1'b1;
                    pend_ovf_reg <= 1'b1;
                end
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            res_acc_reg   <= pend_acc_reg;
            res_found_reg <= pend_found_reg;
            res_cost_reg  <= pend_cost_reg;
            res_ovf_reg   <= pend_ovf_reg;
        end
    end

    assign res_tdata = {7'b0, res_ovf_reg, res_cost_reg, res_found_reg, res_acc_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QFULL)
        else $error("queue count beyond depth");

endmodule

[rtl/layered_ring_tree_path_search.sv]
// ----------------------------------------------------------------------------
// layered_ring_tree_path_search
// Best-first path search over a binary tree whose layers are closed into
// rings; nodes carry altitudes, edges cost altitude differences.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit first)
//  s_      | in  | tdata: node_index, altitude, start_node, goal_node; tuser: opcode
//  m_      | out | tdata: accepted, found, path_cost, queue_overflow
//  cfg_    | in  | data: layer_count
//
//  Altitude write: the item is decoded and its result is loaded. Search: a
//  setup, then per pop a linear min scan over the single queue memory port,
//  plus the read, distance and evaluation steps of each neighbor.
//  Reset clears altitudes (valid bits), the queue count and layer_count = 6.
//  A result waits in the output register; the next item is taken meanwhile,
//  and only a finished result stalls while the previous one is not taken.
module layered_ring_tree_path_search #(
    parameter int QUEUE_DEPTH = lrt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lrt_pkg::DIN_W-1:0]   s_tdata,   // node_index, altitude, start, goal
    input  logic                        s_tuser,   // opcode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lrt_pkg::DOUT_W-1:0]  m_tdata,   // accepted, found, path_cost, overflow
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrt_pkg::CFG_W-1:0]   cfg_data
);
    import lrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lrt_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .res_tdata (m_tdata)
    );

endmodule

[tb/sv/lrt_search_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_search_checker
// Watches the item, result and configuration channels of the layered ring
// tree path search block, computes the outcome of every accepted item and
// compares each result transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module lrt_search_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [lrt_pkg::DIN_W-1:0]    s_tdata,   // node_index, altitude, start_node, goal_node
    input  logic                         s_tuser,   // opcode
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [lrt_pkg::DOUT_W-1:0]   m_tdata,   // accepted, found, path_cost, queue_overflow
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [lrt_pkg::CFG_W-1:0]    cfg_data,
    output int                           errors,
    output int                           pending
);
    import lrt_pkg::*;

    typedef struct {
        bit               accepted;
        bit               found;
        bit [PATH_W-1:0]  path_cost;
        bit               overflow;
    } outcome_t;

    outcome_t        outcome_fifo[$];
    longint          alt_tab[NODE_SLOTS];
    bit              seen[NODE_SLOTS];
    int unsigned     best[NODE_SLOTS];
    int unsigned     qprio[QUEUE_DEPTH_DEF];
    int unsigned     qnode[QUEUE_DEPTH_DEF];
    int unsigned     qcnt;
    int unsigned     layer_reg;

    initial begin
        errors    = 0;
        layer_reg = 6;
        qcnt      = 0;
        foreach (alt_tab[i]) alt_tab[i] = 0;
    end

    assign pending = outcome_fifo.size();

    function automatic int unsigned depth_of(int unsigned n);
        int unsigned k;
        k = 0;
        while (n > 1) begin
            n = n >> 1;
            k++;
        end
        return k;
    endfunction

    function automatic longint unsigned udiff(longint a, longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic outcome_t search_outcome(opcode_t op, int unsigned node,
                                                logic signed [ALT_WIDTH-1:0] alt,
                                                int unsigned st, int unsigned gl);
        outcome_t          r;
        int unsigned       lay;
        int unsigned       lim;
        int unsigned       glay;
        longint unsigned   total;
        int unsigned       nb[5];
        int unsigned       cnt;
        int unsigned       u;
        int unsigned       v;
        int unsigned       bi;
        int unsigned       base;
        longint unsigned   d;
        longint unsigned   c;
        longint unsigned   p;
        r = '{0, 0, 0, 0};
        lay = (layer_reg > MAX_LAYERS) ? MAX_LAYERS : layer_reg;
        lim = 1 << lay;
        if (op == OP_WRITE) begin
            if (node == 0 || node >= lim) return r;
            alt_tab[node] = alt;
            r.accepted = 1;
            return r;
        end
        if (st == 0 || st >= lim || gl == 0 || gl >= lim) return r;
        r.accepted = 1;
        glay  = depth_of(gl);
        total = udiff(alt_tab[st], alt_tab[gl]);
        foreach (seen[i]) seen[i] = 0;
        seen[st] = 1;
        best[st] = 0;
        qprio[0] = 0;
        qnode[0] = st;
        qcnt = 1;
        while (qcnt > 0) begin
            bi = 0;
            for (int i = 1; i < qcnt; i++) begin
                if (qprio[i] < qprio[bi] || (qprio[i] == qprio[bi] && qnode[i] < qnode[bi]))
                    bi = i;
            end
            u = qnode[bi];
            qprio[bi] = qprio[qcnt-1];
            qnode[bi] = qnode[qcnt-1];
            qcnt--;
            if (u == gl) begin
                r.found = 1;
                r.path_cost = (best[gl] > PATH_MAX) ? PATH_MAX : PATH_W'(best[gl]);
                return r;
            end
            base = 1 << depth_of(u);
            cnt = 0;
            if (u < lim / 2) begin
                nb[0] = 2 * u;
                nb[1] = 2 * u + 1;
                cnt = 2;
            end
            if (u > 1) begin
                nb[cnt] = u / 2;
                cnt++;
            end
            nb[cnt]   = base + (u - 1) % base;
            nb[cnt+1] = base + ((u - base) + 1) % base;
            cnt += 2;
            // leaves visit ring before parent
            if (u >= lim / 2 && u > 1) begin
                nb[0] = base + (u - 1) % base;
                nb[1] = base + ((u - base) + 1) % base;
                nb[2] = u / 2;
            end
            for (int j = 0; j < cnt; j++) begin
                v = nb[j];
                if (v == 0 || v >= lim) continue;
                d = udiff(alt_tab[u], alt_tab[v]);
                c = best[u] + d;
                if (c > COST_MAX) c = COST_MAX;
                if (seen[v] && c >= best[v]) continue;
                seen[v] = 1;
                best[v] = 32'(c);
                if (qcnt >= QUEUE_DEPTH_DEF) begin
                    r.overflow = 1;
                    qcnt = 0;
                    return r;
                end
                p = c + udiff(total, d) + udiff(depth_of(v), glay);
                if (p > PRIO_MAX) p = PRIO_MAX;
                qprio[qcnt] = 32'(p);
                qnode[qcnt] = v;
                qcnt++;
            end
        end
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (outcome_fifo.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    e = outcome_fifo.pop_front();
                    if (m_tdata[0] !== e.accepted) report("accepted", m_tdata[0], e.accepted);
                    if (m_tdata[1] !== e.found) report("found", m_tdata[1], e.found);
                    if (m_tdata[23:2] !== e.path_cost)
                        report("path_cost", m_tdata[23:2], e.path_cost);
                    if (m_tdata[24] !== e.overflow) report("queue_overflow", m_tdata[24], e.overflow);
                end
            end
            if (s_tvalid && s_tready)
                outcome_fifo.push_back(search_outcome(opcode_t'(s_tuser), s_tdata[5:0],
                                                      s_tdata[21:6], s_tdata[27:22],
                                                      s_tdata[33:28]));
            if (cfg_valid && cfg_ready)
                layer_reg = cfg_data;
        end
    end

endmodule

[tb/sv/layered_ring_tree_path_search_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_ring_tree_path_search_tb
// Drives altitude writes and searches through several layer counts, with
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module layered_ring_tree_path_search_tb;
    import lrt_pkg::*;

    localparam int WATCH_LIMIT = 400000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [DIN_W-1:0]   s_tdata;   // node_index, altitude, start_node, goal_node
    logic               s_tuser;   // opcode
    logic               m_tvalid;
    logic               m_tready;
    logic [DOUT_W-1:0]  m_tdata;   // accepted, found, path_cost, queue_overflow
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    int                 errors;
    int                 pending;
    bit                 calm;
    int                 quiet_cycles;
    int unsigned        cur_layers;

    layered_ring_tree_path_search uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    lrt_search_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial aclk = 0;
    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 21);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send(opcode_t op, int unsigned node, int unsigned alt,
                        int unsigned st, int unsigned gl);
        if (!calm && $urandom_range(99) < 21) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, gl[5:0], st[5:0], alt[15:0], node[5:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // a write leaves no gap to see; allow the block to settle
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_layers(int unsigned v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= CFG_W'(v);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        cur_layers = (v > MAX_LAYERS) ? MAX_LAYERS : v;
    endtask

    function automatic int unsigned pick_node();
        int unsigned lim;
        lim = 1 << cur_layers;
        if (lim > 1 && $urandom_range(99) < 92) return $urandom_range(lim - 1, 1);
        return $urandom_range(63);
    endfunction

    task automatic random_items(int n);
        int unsigned alt;
        for (int i = 0; i < n; i++) begin
            alt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(400);
            if ($urandom_range(99) < 60)
                send(OP_WRITE, pick_node(), alt, $urandom, $urandom);
            else
                send(OP_SEARCH, $urandom, $urandom, pick_node(), pick_node());
        end
    endtask

    initial begin
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = OP_WRITE;
        m_tready  = 0;
        cfg_valid = 0;
        cfg_data  = '0;
        calm      = 0;
        quiet_cycles = 0;
        cur_layers = 6;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part with reset layer count
        send(OP_SEARCH, 0, 0, 1, 63);
        send(OP_WRITE, 1, 16'h8000, 0, 0);
        send(OP_WRITE, 63, 16'h7fff, 63, 63);
        send(OP_WRITE, 0, 16'h1234, 0, 0);
        send(OP_WRITE, 32, 16'hffff, 0, 0);
        send(OP_SEARCH, 0, 0, 1, 63);
        send(OP_SEARCH, 0, 0, 63, 1);
        send(OP_SEARCH, 0, 0, 17, 17);
        send(OP_SEARCH, 0, 0, 0, 5);
        send(OP_SEARCH, 0, 0, 5, 0);
        send(OP_SEARCH, 6'h3f, 16'hffff, 32, 47);
        set_layers(1);
        send(OP_WRITE, 1, 16'h0005, 0, 0);
        send(OP_WRITE, 2, 16'h0005, 0, 0);
        send(OP_SEARCH, 0, 0, 1, 1);
        send(OP_SEARCH, 0, 0, 1, 2);
        set_layers(0);
        send(OP_WRITE, 1, 16'h0007, 0, 0);
        send(OP_SEARCH, 0, 0, 1, 1);
        set_layers(7);
        send(OP_SEARCH, 0, 0, 63, 32);
        send(OP_SEARCH, 0, 0, 1, 40);

        random_items(120);
        set_layers(3);
        random_items(90);
        set_layers(2);
        random_items(50);
        drain();     // sender holds off until every result is back
        calm = 1;
        random_items(60);
        calm = 0;
        set_layers(4);
        random_items(90);
        set_layers(1);
        random_items(25);
        set_layers(5);
        random_items(80);
        set_layers(6);
        random_items(65);

        drain();
        repeat (30) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
